/* hdl/rbq_pkg.sv */
// ----------------------------------------------------------------------------
// rbq_pkg
// Shared types and register index codes for the rotated billboard quad block.
// ----------------------------------------------------------------------------
package rbq_pkg;

    // fixed-point element types
    typedef logic signed [15:0] q14_t;   // Q2.14 trig and camera axes
    typedef logic signed [31:0] prod_t;  // Q.28 product of two Q2.14 values
    typedef logic signed [32:0] q33_t;   // Q.28 sum of two products
    typedef logic signed [49:0] plo_t;   // low partial product of the half size
    typedef logic signed [47:0] phi_t;   // high partial product of the half size
    typedef logic signed [63:0] q64_t;   // full Q.44 product
    typedef logic signed [34:0] q35_t;   // rounded Q16.16 offset vector
    typedef logic signed [36:0] q37_t;   // vertex position before saturation

    // configuration register indexes
    localparam logic [2:0] REG_TOP_X   = 3'd0;
    localparam logic [2:0] REG_TOP_Y   = 3'd1;
    localparam logic [2:0] REG_TOP_Z   = 3'd2;
    localparam logic [2:0] REG_RIGHT_X = 3'd3;
    localparam logic [2:0] REG_RIGHT_Y = 3'd4;
    localparam logic [2:0] REG_RIGHT_Z = 3'd5;

    // reset values of the camera axes
    localparam q14_t AXIS_ONE  = 16'sd16384;
    localparam q14_t AXIS_ZERO = 16'sd0;

    // rounding bias for Q.44 to Q16.16
    localparam q64_t ROUND_BIAS = 64'sd134217728;

    // corner holding the final vertex of a quad
    localparam logic [1:0] LAST_CORNER = 2'd3;

    // sprite fields that ride along with the arithmetic
    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        half_width;
        logic [30:0]        half_height;
        logic [16:0]        lt_u;
        logic [16:0]        lt_v;
        logic [16:0]        rb_u;
        logic [16:0]        rb_v;
        logic [31:0]        color;
    } side_t;

endpackage

/* hdl/rotated_billboard_quad.sv */
// ----------------------------------------------------------------------------
// rotated_billboard_quad
// Expands one sprite into four camera-facing, rotated quad vertices.
// ----------------------------------------------------------------------------
// A sprite is taken when start is high and busy is low. Busy is raised by
// each accepted sprite and held by a three-bit shift register, so sprites are
// spaced for the single vertex port to emit the four corners of one before
// those of the next; a sprite can be taken while earlier ones are still in
// the pipeline. The other three vertices follow the first on consecutive
// cycles, each marked by vertex_valid for one cycle and corner 3 carrying
// last; the receiver cannot stall.
// Internally a six-stage pipeline (trig products, rotation sums, half-size
// partial products, rounding, corner hold, output) carries a valid bit per
// stage. Camera axis registers should only be written while no sprite is in
// flight.
// ----------------------------------------------------------------------------
module rotated_billboard_quad (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic [30:0]        half_width,
    input  logic [30:0]        half_height,
    input  logic signed [15:0] rot_sine,
    input  logic signed [15:0] rot_cosine,
    input  logic [16:0]        lt_u,
    input  logic [16:0]        lt_v,
    input  logic [16:0]        rb_u,
    input  logic [16:0]        rb_v,
    input  logic [31:0]        sprite_color,
    output logic               vertex_valid,
    output logic signed [31:0] vertex_x,
    output logic signed [31:0] vertex_y,
    output logic signed [31:0] vertex_z,
    output logic [31:0]        vertex_color,
    output logic [16:0]        tex_u,
    output logic [16:0]        tex_v,
    output logic [1:0]         corner,
    output logic               last
);

    rbq_pkg::q14_t  cam_top_reg [3];
    rbq_pkg::q14_t  cam_right_reg [3];
    logic [2:0]     spacing_reg;
    logic           accept;
    rbq_pkg::side_t in_side;
    logic           rot_valid;
    rbq_pkg::q33_t  sum_r [3];
    rbq_pkg::q33_t  sum_t [3];
    rbq_pkg::side_t rot_side;
    logic           scale_valid;
    rbq_pkg::q35_t  vr [3];
    rbq_pkg::q35_t  vt [3];
    rbq_pkg::side_t scale_side;

    // transaction acceptance and sprite spacing
    assign accept = start && !busy;
    assign busy   = |spacing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            spacing_reg <= 3'b000;
        else
            spacing_reg <= {spacing_reg[1:0], accept};
    end

    // camera axis registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_top_reg[0]   <= rbq_pkg::AXIS_ZERO;
            cam_top_reg[1]   <= rbq_pkg::AXIS_ONE;
            cam_top_reg[2]   <= rbq_pkg::AXIS_ZERO;
            cam_right_reg[0] <= rbq_pkg::AXIS_ONE;
            cam_right_reg[1] <= rbq_pkg::AXIS_ZERO;
            cam_right_reg[2] <= rbq_pkg::AXIS_ZERO;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rbq_pkg::REG_TOP_X:   cam_top_reg[0]   <= signed'(cfg_data);
                rbq_pkg::REG_TOP_Y:   cam_top_reg[1]   <= signed'(cfg_data);
                rbq_pkg::REG_TOP_Z:   cam_top_reg[2]   <= signed'(cfg_data);
                rbq_pkg::REG_RIGHT_X: cam_right_reg[0] <= signed'(cfg_data);
                rbq_pkg::REG_RIGHT_Y: cam_right_reg[1] <= signed'(cfg_data);
                rbq_pkg::REG_RIGHT_Z: cam_right_reg[2] <= signed'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    // sprite fields carried alongside the arithmetic
    always_comb
    begin
        in_side.center_x    = center_x;
        in_side.center_y    = center_y;
        in_side.center_z    = center_z;
        in_side.half_width  = half_width;
        in_side.half_height = half_height;
        in_side.lt_u        = lt_u;
        in_side.lt_v        = lt_v;
        in_side.rb_u        = rb_u;
        in_side.rb_v        = rb_v;
        in_side.color       = sprite_color;
    end

    // rotation stages
    rbq_rotate u_rotate (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .rot_sine   (rot_sine),
        .rot_cosine (rot_cosine),
        .cam_top    (cam_top_reg),
        .cam_right  (cam_right_reg),
        .in_side    (in_side),
        .out_valid  (rot_valid),
        .sum_r      (sum_r),
        .sum_t      (sum_t),
        .out_side   (rot_side)
    );

    // half-size scaling stages
    rbq_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .sum_r     (sum_r),
        .sum_t     (sum_t),
        .in_side   (rot_side),
        .out_valid (scale_valid),
        .vr        (vr),
        .vt        (vt),
        .out_side  (scale_side)
    );

    // corner emission
    rbq_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (scale_valid),
        .vr           (vr),
        .vt           (vt),
        .in_side      (scale_side),
        .vertex_valid (vertex_valid),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .vertex_z     (vertex_z),
        .vertex_color (vertex_color),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .corner       (corner),
        .last         (last)
    );

    // an accepted transaction raises busy through the spacing register
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after accepted transaction");

    // first corner of an accepted sprite leaves the pipeline as corner 0
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##6 (vertex_valid && corner == 2'd0))
        else $error("first vertex missing at expected latency");

endmodule

/* hdl/rbq_rotate.sv */
// ----------------------------------------------------------------------------
// rbq_rotate
// Two-stage rotation of the camera axes: trig products, then the unit-scale
// right and up vectors (T*sin + R*cos, T*cos - R*sin) per axis component.
// ----------------------------------------------------------------------------
module rbq_rotate (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  rbq_pkg::q14_t  rot_sine,
    input  rbq_pkg::q14_t  rot_cosine,
    input  rbq_pkg::q14_t  cam_top [3],
    input  rbq_pkg::q14_t  cam_right [3],
    input  rbq_pkg::side_t in_side,
    output logic           out_valid,
    output rbq_pkg::q33_t  sum_r [3],
    output rbq_pkg::q33_t  sum_t [3],
    output rbq_pkg::side_t out_side
);

    rbq_pkg::prod_t ts_reg [3];
    rbq_pkg::prod_t rc_reg [3];
    rbq_pkg::prod_t tc_reg [3];
    rbq_pkg::prod_t rs_reg [3];
    rbq_pkg::prod_t ts_next [3];
    rbq_pkg::prod_t rc_next [3];
    rbq_pkg::prod_t tc_next [3];
    rbq_pkg::prod_t rs_next [3];
    rbq_pkg::q33_t  sum_r_reg [3];
    rbq_pkg::q33_t  sum_t_reg [3];
    rbq_pkg::q33_t  sum_r_next [3];
    rbq_pkg::q33_t  sum_t_next [3];
    rbq_pkg::side_t side_a_reg;
    rbq_pkg::side_t side_b_reg;
    logic           valid_a_reg;
    logic           valid_b_reg;

    // stage a: axis times trig products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ts_next[i] = rbq_pkg::prod_t'(cam_top[i]) * rbq_pkg::prod_t'(rot_sine);
            rc_next[i] = rbq_pkg::prod_t'(cam_right[i]) * rbq_pkg::prod_t'(rot_cosine);
            tc_next[i] = rbq_pkg::prod_t'(cam_top[i]) * rbq_pkg::prod_t'(rot_cosine);
            rs_next[i] = rbq_pkg::prod_t'(cam_right[i]) * rbq_pkg::prod_t'(rot_sine);
        end
    end

    // stage b: rotated unit right and up vectors
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_r_next[i] = rbq_pkg::q33_t'(ts_reg[i]) + rbq_pkg::q33_t'(rc_reg[i]);
            sum_t_next[i] = rbq_pkg::q33_t'(tc_reg[i]) - rbq_pkg::q33_t'(rs_reg[i]);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            ts_reg[i]    <= ts_next[i];
            rc_reg[i]    <= rc_next[i];
            tc_reg[i]    <= tc_next[i];
            rs_reg[i]    <= rs_next[i];
            sum_r_reg[i] <= sum_r_next[i];
            sum_t_reg[i] <= sum_t_next[i];
        end
        side_a_reg <= in_side;
        side_b_reg <= side_a_reg;
    end

    assign out_valid = valid_b_reg;
    assign sum_r     = sum_r_reg;
    assign sum_t     = sum_t_reg;
    assign out_side  = side_b_reg;

endmodule

/* hdl/rbq_scale.sv */
// ----------------------------------------------------------------------------
// rbq_scale
// Scales the unit vectors by the half sizes in two stages: split partial
// products of the 31-bit half size, then recombine and round to Q16.16.
// ----------------------------------------------------------------------------
module rbq_scale (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  rbq_pkg::q33_t  sum_r [3],
    input  rbq_pkg::q33_t  sum_t [3],
    input  rbq_pkg::side_t in_side,
    output logic           out_valid,
    output rbq_pkg::q35_t  vr [3],
    output rbq_pkg::q35_t  vt [3],
    output rbq_pkg::side_t out_side
);

    rbq_pkg::plo_t  rlo_reg [3];
    rbq_pkg::phi_t  rhi_reg [3];
    rbq_pkg::plo_t  tlo_reg [3];
    rbq_pkg::phi_t  thi_reg [3];
    rbq_pkg::plo_t  rlo_next [3];
    rbq_pkg::phi_t  rhi_next [3];
    rbq_pkg::plo_t  tlo_next [3];
    rbq_pkg::phi_t  thi_next [3];
    rbq_pkg::q35_t  vr_reg [3];
    rbq_pkg::q35_t  vt_reg [3];
    rbq_pkg::q35_t  vr_next [3];
    rbq_pkg::q35_t  vt_next [3];
    rbq_pkg::q64_t  acc_r [3];
    rbq_pkg::q64_t  acc_t [3];
    rbq_pkg::side_t side_c_reg;
    rbq_pkg::side_t side_d_reg;
    logic           valid_c_reg;
    logic           valid_d_reg;
    logic signed [16:0] hw_lo;
    logic signed [16:0] hh_lo;
    logic signed [15:0] hw_hi;
    logic signed [15:0] hh_hi;

    // half sizes split into 16 low and 15 high bits, both non-negative
    assign hw_lo = signed'({1'b0, in_side.half_width[15:0]});
    assign hh_lo = signed'({1'b0, in_side.half_height[15:0]});
    assign hw_hi = signed'({1'b0, in_side.half_width[30:16]});
    assign hh_hi = signed'({1'b0, in_side.half_height[30:16]});

    // stage c: partial products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rlo_next[i] = rbq_pkg::plo_t'(hw_lo) * rbq_pkg::plo_t'(sum_r[i]);
            rhi_next[i] = rbq_pkg::phi_t'(hw_hi) * rbq_pkg::phi_t'(sum_r[i]);
            tlo_next[i] = rbq_pkg::plo_t'(hh_lo) * rbq_pkg::plo_t'(sum_t[i]);
            thi_next[i] = rbq_pkg::phi_t'(hh_hi) * rbq_pkg::phi_t'(sum_t[i]);
        end
    end

    // stage d: recombine, add half an lsb, floor shift by 28
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_r[i] = (rbq_pkg::q64_t'(rhi_reg[i]) <<< 16) + rbq_pkg::q64_t'(rlo_reg[i])
                       + rbq_pkg::ROUND_BIAS;
            acc_t[i] = (rbq_pkg::q64_t'(thi_reg[i]) <<< 16) + rbq_pkg::q64_t'(tlo_reg[i])
                       + rbq_pkg::ROUND_BIAS;
            vr_next[i] = acc_r[i][62:28];
            vt_next[i] = acc_t[i][62:28];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end
        else
        begin
            valid_c_reg <= in_valid;
            valid_d_reg <= valid_c_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            rlo_reg[i] <= rlo_next[i];
            rhi_reg[i] <= rhi_next[i];
            tlo_reg[i] <= tlo_next[i];
            thi_reg[i] <= thi_next[i];
            vr_reg[i]  <= vr_next[i];
            vt_reg[i]  <= vt_next[i];
        end
        side_c_reg <= in_side;
        side_d_reg <= side_c_reg;
    end

    assign out_valid = valid_d_reg;
    assign vr        = vr_reg;
    assign vt        = vt_reg;
    assign out_side  = side_d_reg;

endmodule

/* hdl/rbq_emit.sv */
// ----------------------------------------------------------------------------
// rbq_emit
// Holds one scaled sprite and emits its four corners on consecutive cycles,
// each with saturated position, texture coordinates, color and last flag.
// ----------------------------------------------------------------------------
module rbq_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  rbq_pkg::q35_t      vr [3],
    input  rbq_pkg::q35_t      vt [3],
    input  rbq_pkg::side_t     in_side,
    output logic               vertex_valid,
    output logic signed [31:0] vertex_x,
    output logic signed [31:0] vertex_y,
    output logic signed [31:0] vertex_z,
    output logic [31:0]        vertex_color,
    output logic [16:0]        tex_u,
    output logic [16:0]        tex_v,
    output logic [1:0]         corner,
    output logic               last
);

    rbq_pkg::q35_t      vr_hold_reg [3];
    rbq_pkg::q35_t      vt_hold_reg [3];
    rbq_pkg::side_t     side_hold_reg;
    logic               active_reg;
    logic [1:0]         corner_reg;
    rbq_pkg::q37_t      center [3];
    rbq_pkg::q37_t      pos [3];
    logic signed [31:0] pos_sat [3];
    logic               out_valid_reg;
    logic signed [31:0] out_pos_reg [3];
    logic [31:0]        out_color_reg;
    logic [16:0]        out_u_reg;
    logic [16:0]        out_v_reg;
    logic [1:0]         out_corner_reg;
    logic               out_last_reg;

    assign center[0] = rbq_pkg::q37_t'(side_hold_reg.center_x);
    assign center[1] = rbq_pkg::q37_t'(side_hold_reg.center_y);
    assign center[2] = rbq_pkg::q37_t'(side_hold_reg.center_z);

    // corner position: low bit picks +vt, high bit picks +vr; then saturate
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pos[i] = center[i]
                     + (corner_reg[0] ? rbq_pkg::q37_t'(vt_hold_reg[i])
                                      : -rbq_pkg::q37_t'(vt_hold_reg[i]))
                     + (corner_reg[1] ? rbq_pkg::q37_t'(vr_hold_reg[i])
                                      : -rbq_pkg::q37_t'(vr_hold_reg[i]));
            if (pos[i][36:31] == 6'b000000 || pos[i][36:31] == 6'b111111)
                pos_sat[i] = pos[i][31:0];
            else if (pos[i][36])
                pos_sat[i] = 32'sh8000_0000;
            else
                pos_sat[i] = 32'sh7FFF_FFFF;
        end
    end

    // corner sequencing; a new sprite replaces the finished one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            corner_reg    <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= active_reg;
            if (in_valid)
            begin
                active_reg <= 1'b1;
                corner_reg <= 2'd0;
            end
            else if (active_reg)
            begin
                corner_reg <= corner_reg + 2'd1;
                if (corner_reg == rbq_pkg::LAST_CORNER)
                    active_reg <= 1'b0;
            end
        end
    end

    // sprite hold and output registers
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            vr_hold_reg   <= vr;
            vt_hold_reg   <= vt;
            side_hold_reg <= in_side;
        end
        out_pos_reg    <= pos_sat;
        out_color_reg  <= side_hold_reg.color;
        out_u_reg      <= corner_reg[1] ? side_hold_reg.rb_u : side_hold_reg.lt_u;
        out_v_reg      <= corner_reg[0] ? side_hold_reg.lt_v : side_hold_reg.rb_v;
        out_corner_reg <= corner_reg;
        out_last_reg   <= (corner_reg == rbq_pkg::LAST_CORNER);
    end

    assign vertex_valid = out_valid_reg;
    assign vertex_x     = out_pos_reg[0];
    assign vertex_y     = out_pos_reg[1];
    assign vertex_z     = out_pos_reg[2];
    assign vertex_color = out_color_reg;
    assign tex_u        = out_u_reg;
    assign tex_v        = out_v_reg;
    assign corner       = out_corner_reg;
    assign last         = out_last_reg;

    // last flag marks only the final corner
    assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid |-> (last == (corner == rbq_pkg::LAST_CORNER)))
        else $error("last flag does not match corner");

    // corners of one quad come out on consecutive cycles in order
    assert property (@(posedge clk) disable iff (!rst_n)
        (vertex_valid && !last) |=> (vertex_valid && corner == $past(corner) + 2'd1))
        else $error("quad corners not emitted back to back");

endmodule
